[rtl/core/rae_pkg.sv]
// Package for the reliable datagram ARQ engine: sizes, codes, payload and command types.
// No dependencies; every module of the engine imports it.
package rae_pkg;

    localparam int NUM_PEERS   = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_PAYLOAD = 1024;

    localparam int PEER_W    = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_PEERS * QUEUE_DEPTH;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [7:0]  ACK_EVENT     = 8'd111;
    localparam logic [15:0] TIMEOUT_RESET = 16'd400;
    localparam logic [7:0]  TRIES_RESET   = 8'd10;

    localparam logic [2:0] OP_SEND     = 3'd0;
    localparam logic [2:0] OP_SEND_REL = 3'd1;
    localparam logic [2:0] OP_RECV     = 3'd2;
    localparam logic [2:0] OP_POLL     = 3'd3;
    localparam logic [2:0] OP_TICK     = 3'd4;

    localparam logic [2:0] KIND_TX    = 3'd0;
    localparam logic [2:0] KIND_ACK   = 3'd1;
    localparam logic [2:0] KIND_DLVR  = 3'd2;
    localparam logic [2:0] KIND_LOST  = 3'd3;
    localparam logic [2:0] KIND_FULL  = 3'd4;

    localparam logic       CFG_TIMEOUT = 1'b0;
    localparam logic       CFG_TRIES   = 1'b1;

    typedef enum logic [2:0] {
        CMD_SEND,
        CMD_SEND_REL,
        CMD_RX_DATA,
        CMD_RX_ACK,
        CMD_RX_REL,
        CMD_POLL,
        CMD_TICK
    } t_cmd_kind;

    typedef struct packed {
        logic [2:0]  operation;
        logic [2:0]  peer;
        logic        reliable;
        logic [31:0] packet_id;
        logic [7:0]  event_id;
        logic [10:0] length;
        logic [7:0]  buffer_handle;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  out_peer;
        logic        out_reliable;
        logic [31:0] out_packet_id;
        logic [7:0]  out_event_id;
        logic [10:0] out_length;
        logic [7:0]  out_buffer_handle;
        logic        last;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind   op;
        logic [2:0]  peer;
        logic [31:0] pid;
        logic [7:0]  ev;
        logic [10:0] len;
        logic [7:0]  handle;
    } t_cmd;

    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  ev;
        logic [10:0] len;
        logic [7:0]  handle;
    } t_entry;

endpackage

[rtl/core/rae_front.sv]
// Front end: accepts input transfers, classifies them into commands, holds a two-entry queue.
// Depends on rae_pkg.
module rae_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  rae_pkg::t_in_item i_in_data,
    output logic            o_cmd_vld,
    output rae_pkg::t_cmd   o_cmd,
    input  logic            i_cmd_pop
);
    import rae_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       keep;
    logic       push;
    logic       pop;

    always_comb begin
        n_cmd.peer   = i_in_data.peer;
        n_cmd.pid    = i_in_data.packet_id;
        n_cmd.ev     = i_in_data.event_id;
        n_cmd.handle = i_in_data.buffer_handle;
        if (17'(i_in_data.length) > 17'(MAX_PAYLOAD)) begin
            n_cmd.len = 11'(MAX_PAYLOAD);
        end else begin
            n_cmd.len = i_in_data.length;
        end
        keep = 7'(i_in_data.peer) < 7'(NUM_PEERS);
        case (i_in_data.operation)
            OP_SEND:     n_cmd.op = CMD_SEND;
            OP_SEND_REL: n_cmd.op = CMD_SEND_REL;
            OP_RECV: begin
                if (!i_in_data.reliable) begin
                    n_cmd.op = CMD_RX_DATA;
                end else if (i_in_data.event_id == ACK_EVENT) begin
                    n_cmd.op = CMD_RX_ACK;
                end else begin
                    n_cmd.op = CMD_RX_REL;
                end
            end
            OP_POLL: begin
                n_cmd.op = CMD_POLL;
                keep = 1'b1;
            end
            OP_TICK: begin
                n_cmd.op = CMD_TICK;
                keep = 1'b1;
            end
            default: begin
                n_cmd.op = CMD_TICK;
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall && keep;
    assign o_cmd_vld  = (r_cnt != 2'd0);
    assign o_cmd      = r_q[r_rp];
    assign pop        = i_cmd_pop && o_cmd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

endmodule

[rtl/core/rae_back.sv]
// Back end: per-peer send queues, sequence state, poll scan and the result output register.
// Depends on rae_pkg; takes commands from rae_front.
module rae_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_vld,
    input  rae_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    input  logic [15:0]      i_timeout,
    input  logic [7:0]       i_max_tries,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output rae_pkg::t_out_item o_out_data
);
    import rae_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHK,
        S_RX2,
        S_PSCAN,
        S_PCHK,
        S_PLOST,
        S_DONE
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [PEER_W-1:0]  r_pidx;
    logic [31:0]        r_next_id;
    logic [31:0]        r_ms;
    logic [QPTR_W-1:0]  r_head  [NUM_PEERS];
    logic [QCNT_W-1:0]  r_cnt   [NUM_PEERS];
    logic [7:0]         r_tries [NUM_PEERS];
    logic [31:0]        r_last  [NUM_PEERS];
    logic [31:0]        r_ldel  [NUM_PEERS];
    t_entry             r_mem   [MEM_DEPTH];
    t_entry             r_rd;
    t_out_item          r_hold;
    logic               r_hold_vld;
    logic               r_hold_fin;
    t_out_item          r_out;
    logic               r_out_vld;

    logic [PEER_W-1:0]  cur;
    logic [QPTR_W-1:0]  head_c;
    logic [QCNT_W-1:0]  cnt_c;
    logic [7:0]         tries_c;
    logic [QCNT_W:0]    slot_sum;
    logic [QPTR_W-1:0]  slot;
    logic [MEM_AW-1:0]  wr_addr;
    logic [MEM_AW-1:0]  rd_addr;
    logic               full;
    logic               resend;
    logic               lost;
    logic               want_emit;
    t_out_item          n_res;
    logic               out_free;
    logic               hold_mv;
    logic               emit_ok;
    logic               mem_we;
    t_entry             wr_data;

    always_comb begin
        if (r_state == S_PSCAN || r_state == S_PCHK || r_state == S_PLOST) begin
            cur = r_pidx;
        end else begin
            cur = r_cmd.peer[PEER_W-1:0];
        end
    end

    assign head_c   = r_head[cur];
    assign cnt_c    = r_cnt[cur];
    assign tries_c  = r_tries[cur];
    assign slot_sum = (QCNT_W+1)'(head_c) + (QCNT_W+1)'(cnt_c);
    assign slot     = (slot_sum >= (QCNT_W+1)'(QUEUE_DEPTH))
                    ? QPTR_W'(slot_sum - (QCNT_W+1)'(QUEUE_DEPTH)) : QPTR_W'(slot_sum);
    assign wr_addr  = MEM_AW'(MEM_AW'(cur) * MEM_AW'(QUEUE_DEPTH)) + MEM_AW'(slot);
    assign rd_addr  = MEM_AW'(MEM_AW'(cur) * MEM_AW'(QUEUE_DEPTH)) + MEM_AW'(head_c);
    assign full     = cnt_c >= QCNT_W'(QUEUE_DEPTH);
    assign resend   = (tries_c == 8'd0) || ((r_ms - r_last[cur]) > {16'd0, i_timeout});
    assign lost     = tries_c > i_max_tries;

    assign wr_data.id     = r_next_id;
    assign wr_data.ev     = r_cmd.ev;
    assign wr_data.len    = r_cmd.len;
    assign wr_data.handle = r_cmd.handle;

    always_comb begin
        want_emit               = 1'b0;
        n_res.kind              = KIND_TX;
        n_res.out_peer          = 3'(cur);
        n_res.out_reliable      = 1'b0;
        n_res.out_packet_id     = r_cmd.pid;
        n_res.out_event_id      = r_cmd.ev;
        n_res.out_length        = r_cmd.len;
        n_res.out_buffer_handle = r_cmd.handle;
        n_res.last              = 1'b0;
        case (r_state)
            S_EXEC: begin
                case (r_cmd.op)
                    CMD_SEND: begin
                        want_emit           = 1'b1;
                        n_res.out_packet_id = r_next_id;
                    end
                    CMD_SEND_REL: begin
                        want_emit          = full || (cnt_c == '0);
                        n_res.out_reliable = 1'b1;
                        if (full) begin
                            n_res.kind          = KIND_FULL;
                            n_res.out_packet_id = 32'd0;
                        end else begin
                            n_res.out_packet_id = r_next_id;
                        end
                    end
                    CMD_RX_DATA: begin
                        want_emit  = 1'b1;
                        n_res.kind = KIND_DLVR;
                    end
                    CMD_RX_REL: begin
                        want_emit               = 1'b1;
                        n_res.kind              = KIND_ACK;
                        n_res.out_reliable      = 1'b1;
                        n_res.out_event_id      = ACK_EVENT;
                        n_res.out_length        = 11'd0;
                        n_res.out_buffer_handle = 8'd0;
                    end
                    default: want_emit = 1'b0;
                endcase
            end
            S_RX2: begin
                want_emit          = 1'b1;
                n_res.kind         = KIND_DLVR;
                n_res.out_reliable = 1'b1;
            end
            S_PCHK, S_PLOST: begin
                want_emit               = (r_state == S_PCHK) ? resend : lost;
                n_res.kind              = (r_state == S_PCHK) ? KIND_TX : KIND_LOST;
                n_res.out_reliable      = (r_state == S_PCHK);
                n_res.out_packet_id     = r_rd.id;
                n_res.out_event_id      = r_rd.ev;
                n_res.out_length        = r_rd.len;
                n_res.out_buffer_handle = r_rd.handle;
            end
            default: want_emit = 1'b0;
        endcase
    end

    assign out_free  = !r_out_vld || !i_out_stall;
    assign hold_mv   = r_hold_vld && (r_hold_fin || want_emit) && out_free;
    assign emit_ok   = !r_hold_vld || hold_mv;
    assign o_cmd_pop = (r_state == S_IDLE);
    assign mem_we    = (r_state == S_EXEC) && (r_cmd.op == CMD_SEND_REL) && !full
                    && ((cnt_c != '0) || emit_ok);

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (hold_mv) begin
            r_out <= {r_hold[$bits(t_out_item)-1:1], r_hold_fin};
        end
        if (want_emit && emit_ok) begin
            r_hold <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cmd      <= '0;
            r_pidx     <= '0;
            r_next_id  <= '0;
            r_ms       <= '0;
            r_hold_vld <= 1'b0;
            r_hold_fin <= 1'b0;
            r_out_vld  <= 1'b0;
            for (int i = 0; i < NUM_PEERS; i++) begin
                r_head[i]  <= '0;
                r_cnt[i]   <= '0;
                r_tries[i] <= '0;
                r_last[i]  <= '0;
                r_ldel[i]  <= '0;
            end
        end else begin
            if (hold_mv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (want_emit && emit_ok) begin
                r_hold_vld <= 1'b1;
                r_hold_fin <= 1'b0;
            end else if (hold_mv) begin
                r_hold_vld <= 1'b0;
                r_hold_fin <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cmd_vld) begin
                        r_cmd   <= i_cmd;
                        r_pidx  <= '0;
                        r_state <= (i_cmd.op == CMD_POLL) ? S_PSCAN : S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_cmd.op)
                        CMD_TICK: begin
                            r_ms    <= r_ms + 32'd1;
                            r_state <= S_DONE;
                        end
                        CMD_SEND, CMD_RX_DATA: begin
                            if (emit_ok) begin
                                if (r_cmd.op == CMD_SEND) begin
                                    r_next_id <= r_next_id + 32'd1;
                                end
                                r_state <= S_DONE;
                            end
                        end
                        CMD_SEND_REL: begin
                            if (full) begin
                                if (emit_ok) begin
                                    r_state <= S_DONE;
                                end
                            end else if (mem_we) begin
                                r_next_id  <= r_next_id + 32'd1;
                                r_cnt[cur] <= cnt_c + QCNT_W'(1);
                                if (cnt_c == '0) begin
                                    r_tries[cur] <= 8'd1;
                                    r_last[cur]  <= r_ms;
                                end
                                r_state <= S_DONE;
                            end
                        end
                        CMD_RX_ACK: begin
                            r_state <= (cnt_c == '0) ? S_DONE : S_CHK;
                        end
                        CMD_RX_REL: begin
                            if (emit_ok) begin
                                r_state <= (r_cmd.pid > r_ldel[cur]) ? S_RX2 : S_DONE;
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_CHK: begin
                    if (r_rd.id == r_cmd.pid) begin
                        r_head[cur]  <= (head_c == QPTR_W'(QUEUE_DEPTH - 1))
                                      ? '0 : head_c + QPTR_W'(1);
                        r_cnt[cur]   <= cnt_c - QCNT_W'(1);
                        r_tries[cur] <= 8'd0;
                    end
                    r_state <= S_DONE;
                end
                S_RX2: begin
                    if (emit_ok) begin
                        r_ldel[cur] <= r_cmd.pid;
                        r_state     <= S_DONE;
                    end
                end
                S_PSCAN: begin
                    if (cnt_c != '0) begin
                        r_state <= S_PCHK;
                    end else if (r_pidx == PEER_W'(NUM_PEERS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_pidx <= r_pidx + PEER_W'(1);
                    end
                end
                S_PCHK: begin
                    if (!resend) begin
                        r_state <= S_PLOST;
                    end else if (emit_ok) begin
                        r_last[cur] <= r_ms;
                        if (tries_c != 8'hFF) begin
                            r_tries[cur] <= tries_c + 8'd1;
                        end
                        r_state <= S_PLOST;
                    end
                end
                S_PLOST: begin
                    if (!lost || emit_ok) begin
                        if (r_pidx == PEER_W'(NUM_PEERS - 1)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_pidx  <= r_pidx + PEER_W'(1);
                            r_state <= S_PSCAN;
                        end
                    end
                end
                S_DONE: begin
                    if (r_hold_vld && !hold_mv) begin
                        r_hold_fin <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/core/reliable_datagram_arq_engine_top.sv]
// Top level of the reliable datagram ARQ engine: configuration registers, front and back.
// Depends on rae_pkg, rae_front and rae_back.
//
//   channel  direction  handshake              payload
//   in       input      i_in_valid/o_in_stall  i_in_data (t_in_item)
//   out      output     o_out_valid/i_out_stall o_out_data (t_out_item)
//   cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Sends, receives and ticks pass through the states EXEC, CHK or RX2 where needed, and
// DONE; a poll visits PSCAN per peer slot and PCHK and PLOST per non-empty queue.
// A two-entry command queue lets the front accept while the back is busy.
// Reset is synchronous; queue entry memory is not cleared. Output stall holds the back.
module reliable_datagram_arq_engine_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rae_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rae_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import rae_pkg::*;

    logic [15:0] r_timeout;
    logic [7:0]  r_max_tries;
    logic        cmd_vld;
    t_cmd        cmd;
    logic        cmd_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_max_tries <= TRIES_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIMEOUT: r_timeout   <= i_cfg_data;
                CFG_TRIES:   r_max_tries <= i_cfg_data[7:0];
                default:     r_timeout   <= r_timeout;
            endcase
        end
    end

    rae_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_cmd_vld  (cmd_vld),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    rae_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_vld   (cmd_vld),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_timeout   (r_timeout),
        .i_max_tries (r_max_tries),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

[dv/reliable_datagram_arq_engine_top_tb.sv]
// Self-checking testbench for the stop-and-wait ARQ engine top level.
// Depends on rae_pkg and reliable_datagram_arq_engine_top; a behavioral predictor
// checks every result transfer, with random idling on both channels.
module reliable_datagram_arq_engine_top_tb;
    import rae_pkg::*;

    localparam int IDLE_MAX   = 18;
    localparam int WDOG_LIMIT = 4000;
    localparam int DRAIN_CYC  = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    reliable_datagram_arq_engine_top dut (.*);

    // predictor state
    logic [15:0] p_timeout;
    logic [7:0]  p_max_tries;
    logic [31:0] p_next_id;
    logic [31:0] p_ms;
    t_entry      p_mem [NUM_PEERS][QUEUE_DEPTH];
    logic [3:0]  p_head [NUM_PEERS];
    logic [4:0]  p_count [NUM_PEERS];
    logic [7:0]  p_tries [NUM_PEERS];
    logic [31:0] p_last_try [NUM_PEERS];
    logic [31:0] p_last_dlvr [NUM_PEERS];

    t_out_item   expected_q [$];
    int          fail_cnt;
    int          result_cnt;
    int          item_cnt;
    int          wdog;
    bit          wdog_armed;
    int          out_wait;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out_item make_result(logic [2:0] k, logic [2:0] pr, logic rel,
                                              logic [31:0] id, logic [7:0] ev,
                                              logic [10:0] len, logic [7:0] hd);
        t_out_item r;
        r = '{k, pr, rel, id, ev, len, hd, 1'b0};
        return r;
    endfunction

    task automatic predict_engine(input t_in_item it);
        t_out_item   res [$];
        t_entry      e;
        logic [10:0] len;
        logic [3:0]  slot;
        int          pr;
        len = (it.length > MAX_PAYLOAD) ? 11'(MAX_PAYLOAD) : it.length;
        pr = it.peer;
        if (it.operation == OP_TICK) begin
            p_ms++;
        end else if (it.operation == OP_POLL) begin
            for (int p = 0; p < NUM_PEERS; p++) begin
                if (p_count[p] == 0) continue;
                e = p_mem[p][p_head[p]];
                if (p_tries[p] == 0 || (p_ms - p_last_try[p]) > {16'd0, p_timeout}) begin
                    p_last_try[p] = p_ms;
                    if (p_tries[p] < 8'd255) p_tries[p]++;
                    res.push_back(make_result(KIND_TX, 3'(p), 1'b1, e.id, e.ev, e.len,
                                              e.handle));
                end
                if (p_tries[p] > p_max_tries)
                    res.push_back(make_result(KIND_LOST, 3'(p), 1'b0, e.id, e.ev, e.len,
                                              e.handle));
            end
        end else if (it.operation == OP_SEND) begin
            res.push_back(make_result(KIND_TX, it.peer, 1'b0, p_next_id, it.event_id, len,
                                      it.buffer_handle));
            p_next_id++;
        end else if (it.operation == OP_SEND_REL) begin
            if (p_count[pr] >= QUEUE_DEPTH) begin
                res.push_back(make_result(KIND_FULL, it.peer, 1'b1, 32'd0, it.event_id, len,
                                          it.buffer_handle));
            end else begin
                slot = p_head[pr] + 4'(p_count[pr]);
                p_mem[pr][slot] = '{p_next_id, it.event_id, len, it.buffer_handle};
                if (p_count[pr] == 0) begin
                    p_tries[pr] = 8'd1;
                    p_last_try[pr] = p_ms;
                    res.push_back(make_result(KIND_TX, it.peer, 1'b1, p_next_id, it.event_id,
                                              len, it.buffer_handle));
                end
                p_next_id++;
                p_count[pr]++;
            end
        end else if (it.operation == OP_RECV) begin
            if (!it.reliable) begin
                res.push_back(make_result(KIND_DLVR, it.peer, 1'b0, it.packet_id, it.event_id,
                                          len, it.buffer_handle));
            end else if (it.event_id == ACK_EVENT) begin
                if (p_count[pr] > 0 && p_mem[pr][p_head[pr]].id == it.packet_id) begin
                    p_head[pr]++;
                    p_count[pr]--;
                    p_tries[pr] = 8'd0;
                end
            end else begin
                res.push_back(make_result(KIND_ACK, it.peer, 1'b1, it.packet_id, ACK_EVENT,
                                          11'd0, 8'd0));
                if (it.packet_id > p_last_dlvr[pr]) begin
                    p_last_dlvr[pr] = it.packet_id;
                    res.push_back(make_result(KIND_DLVR, it.peer, 1'b1, it.packet_id,
                                              it.event_id, len, it.buffer_handle));
                end
            end
        end
        if (res.size() > 0) res[res.size() - 1].last = 1'b1;
        foreach (res[i]) expected_q.push_back(res[i]);
    endtask

    task automatic send_item(input t_in_item it);
        int gap;
        gap = $urandom_range(0, IDLE_MAX);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_engine(it);
        item_cnt++;
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TIMEOUT) p_timeout = val;
        else p_max_tries = val[7:0];
        @(posedge i_clk);
    endtask

    task automatic wait_idle;
        i_in_valid <= 1'b0;
        wdog_armed = 1'b1;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        wdog_armed = 1'b0;
    endtask

    function automatic t_in_item mk(logic [2:0] op, logic [2:0] pr, logic rel,
                                    logic [31:0] id, logic [7:0] ev, logic [10:0] len,
                                    logic [7:0] hd);
        t_in_item it;
        it = '{op, pr, rel, id, ev, len, hd};
        return it;
    endfunction

    // output side: draw a wait per result, compare each transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_wait = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                result_cnt++;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $realtime, o_out_data);
                    fail_cnt++;
                end else begin
                    if (o_out_data !== expected_q[0]) begin
                        $display("%0t: mismatch expected %p actual %p", $realtime,
                                 expected_q[0], o_out_data);
                        fail_cnt++;
                    end
                    void'(expected_q.pop_front());
                end
                out_wait = $urandom_range(0, IDLE_MAX);
                if ($urandom_range(0, 3) == 0) out_wait = 0;
            end else if (out_wait != 0) begin
                out_wait--;
            end
            i_out_stall <= (out_wait != 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready) || !wdog_armed && expected_q.size() == 0)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $realtime,
                     expected_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    t_in_item directed [] = '{
        mk(OP_SEND, 3'd0, 1'b0, 32'd0, 8'd0, 11'd0, 8'd0),
        mk(OP_SEND, 3'd7, 1'b1, 32'hFFFF_FFFF, 8'd255, 11'd2047, 8'd255),
        mk(OP_SEND_REL, 3'd1, 1'b0, 32'd0, 8'd5, 11'd1024, 8'd9),
        mk(OP_SEND_REL, 3'd1, 1'b0, 32'd0, 8'd6, 11'd1025, 8'd10),
        mk(OP_POLL, 3'd0, 1'b0, 32'd0, 8'd0, 11'd0, 8'd0),
        mk(OP_RECV, 3'd1, 1'b1, 32'd3, ACK_EVENT, 11'd0, 8'd0),
        mk(OP_RECV, 3'd1, 1'b1, 32'd2, ACK_EVENT, 11'd0, 8'd0),
        mk(OP_POLL, 3'd0, 1'b0, 32'd0, 8'd0, 11'd0, 8'd0),
        mk(OP_RECV, 3'd2, 1'b1, 32'd0, ACK_EVENT, 11'd0, 8'd0),
        mk(OP_RECV, 3'd3, 1'b0, 32'hFFFF_FFFF, 8'd255, 11'd2047, 8'd255),
        mk(OP_RECV, 3'd3, 1'b1, 32'd0, 8'd1, 11'd4, 8'd1),
        mk(OP_RECV, 3'd3, 1'b1, 32'hFFFF_FFFF, 8'd2, 11'd4, 8'd1),
        mk(OP_RECV, 3'd3, 1'b1, 32'd5, 8'd2, 11'd4, 8'd1),
        mk(OP_TICK, 3'd0, 1'b0, 32'd0, 8'd0, 11'd0, 8'd0),
        mk(3'd5, 3'd0, 1'b1, 32'd1, 8'd1, 11'd1, 8'd1),
        mk(3'd7, 3'd7, 1'b1, 32'd1, 8'd1, 11'd1, 8'd1),
        mk(OP_POLL, 3'd0, 1'b0, 32'd0, 8'd0, 11'd0, 8'd0)
    };

    t_in_item it;
    int       peer_sel;
    int       phase_items;

    initial begin
        fail_cnt = 0; result_cnt = 0; item_cnt = 0; wdog = 0; wdog_armed = 1'b0;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_data = '0; i_out_stall = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = CFG_TIMEOUT; i_cfg_data = '0;
        p_timeout = TIMEOUT_RESET; p_max_tries = TRIES_RESET;
        p_next_id = '0; p_ms = '0;
        for (int p = 0; p < NUM_PEERS; p++) begin
            p_head[p] = '0; p_count[p] = '0; p_tries[p] = '0;
            p_last_try[p] = '0; p_last_dlvr[p] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        wdog_armed = 1'b1;
        foreach (directed[i]) send_item(directed[i]);
        // fill one queue past its depth
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_item(mk(OP_SEND_REL, 3'd4, 1'b0, 32'd0, 8'(i), 11'(i), 8'(i)));
        wait_idle();

        // phases: timeout/tries settings, extremes included
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin write_reg(CFG_TIMEOUT, 16'd1); write_reg(CFG_TRIES, 16'd1); end
                1: begin write_reg(CFG_TIMEOUT, 16'd3); write_reg(CFG_TRIES, 16'd4); end
                2: begin write_reg(CFG_TIMEOUT, 16'hFFFF); write_reg(CFG_TRIES, 16'd255); end
                default: begin write_reg(CFG_TIMEOUT, 16'd2); write_reg(CFG_TRIES, 16'd3); end
            endcase
            wdog_armed = 1'b1;
            phase_items = 0;
            while (phase_items < 40) begin
                peer_sel = $urandom_range(0, 3);
                case ($urandom_range(0, 9))
                    0, 1: it = mk(OP_SEND_REL, 3'(peer_sel), 1'($urandom), $urandom,
                                  8'($urandom), 11'($urandom_range(0, 1100)), 8'($urandom));
                    2: begin
                        // well-formed ack of the current head, or a stale one
                        it = mk(OP_RECV, 3'(peer_sel), 1'b1, $urandom, ACK_EVENT, 11'($urandom),
                                8'($urandom));
                        if (p_count[peer_sel] != 0 && $urandom_range(0, 3) != 0)
                            it.packet_id = p_mem[peer_sel][p_head[peer_sel]].id;
                        else
                            it.packet_id = p_next_id - 32'($urandom_range(0, 40));
                    end
                    3: it = mk(OP_POLL, 3'($urandom), 1'($urandom), $urandom, 8'($urandom),
                               11'($urandom), 8'($urandom));
                    4, 5: it = mk(OP_TICK, 3'($urandom), 1'($urandom), $urandom, 8'($urandom),
                                  11'($urandom), 8'($urandom));
                    6: it = mk(OP_SEND, 3'($urandom), 1'($urandom), $urandom, 8'($urandom),
                               11'($urandom), 8'($urandom));
                    7: it = mk(OP_RECV, 3'($urandom), 1'($urandom), $urandom,
                               ($urandom_range(0, 3) == 0) ? ACK_EVENT : 8'($urandom),
                               11'($urandom), 8'($urandom));
                    8: it = mk(OP_RECV, 3'(peer_sel), 1'b1,
                               p_last_dlvr[peer_sel] + 32'($urandom_range(0, 4)) - 32'd2,
                               8'($urandom_range(0, 110)), 11'($urandom), 8'($urandom));
                    default: it = mk(3'($urandom_range(5, 7)), 3'($urandom), 1'($urandom),
                                     $urandom, 8'($urandom), 11'($urandom), 8'($urandom));
                endcase
                send_item(it);
                if (it.operation <= OP_TICK) phase_items++;
            end
            wait_idle();
        end

        $display("Covered %0d input transfers and %0d result transfers over five settings.",
                 item_cnt, result_cnt);
        if (fail_cnt == 0 && expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d failures, %0d expectations left", fail_cnt, expected_q.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
